// File: rtl/core/ddo_pkg.sv
package ddo_pkg;

	// Build-time settings
	localparam int CORDIC_STEPS  = 16;
	localparam int POS_FRAC_BITS = 16;

	// Field and register widths
	localparam int ANGLE_W    = 32;
	localparam int NOISE_W    = 16;
	localparam int STAMP_W    = 32;
	localparam int RADIUS_W   = 16;
	localparam int SEP_W      = 18;
	localparam int QUAT_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP    = 1'b1;
	localparam logic [RADIUS_W-1:0]  RADIUS_RST = 16'd2163;
	localparam logic [SEP_W-1:0]     SEP_RST    = 18'd11141;

	// Arithmetic unit widths
	localparam int MUL_A_W  = 64;
	localparam int MUL_B_W  = 32;
	localparam int DIV_N_W  = 72;
	localparam int DIV_D_W  = 44;
	localparam int DIV_CNT_W = 7;
	localparam int CORD_W   = 26;
	localparam int CORD_Z_W = 34;
	localparam int CORD_CNT_W = 5;
	localparam int ACC_W    = 48;
	localparam int RSUM_W   = 50;

	localparam int TRIG_GAIN = 2547003;
	localparam logic [MUL_B_W-1:0] RAD_TO_BA = 32'd683565276;
	localparam logic [MUL_B_W-1:0] VEL_SCALE = 32'd15625;
	localparam int DS_SHIFT  = 33 - POS_FRAC_BITS;
	localparam int POS_DOWN  = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
	localparam int POS_UP    = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

	function automatic logic [31:0] atan_ba(input logic [CORD_CNT_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RSUM,
		ST_RDIF,
		ST_TURN,
		ST_BA,
		ST_COS,
		ST_XINC,
		ST_YINC,
		ST_HALF,
		ST_LINM,
		ST_LIND,
		ST_ANGM,
		ST_ANGT,
		ST_ANGD,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic                       start;
		logic signed [MUL_A_W-1:0]  a;
		logic        [MUL_B_W-1:0]  b;
		logic                       neg;
	} mul_req_t;

	typedef struct packed {
		logic                       done;
		logic                       busy;
		logic signed [MUL_A_W-1:0]  prod;
	} mul_rsp_t;

	typedef struct packed {
		logic                       start;
		logic signed [DIV_N_W-1:0]  num;
		logic        [DIV_D_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                       done;
		logic                       busy;
		logic signed [DIV_N_W-1:0]  quo;
	} div_rsp_t;

	typedef struct packed {
		logic                       start;
		logic        [ANGLE_W-1:0]  angle;
	} cord_req_t;

	typedef struct packed {
		logic                       done;
		logic                       busy;
		logic signed [CORD_W-1:0]   cos_v;
		logic signed [CORD_W-1:0]   sin_v;
	} cord_rsp_t;

endpackage

// File: rtl/core/ddo_if.sv
interface ddo_sample_if import ddo_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [ANGLE_W-1:0]  left_pos;
	logic signed [ANGLE_W-1:0]  right_pos;
	logic signed [NOISE_W-1:0]  left_noise;
	logic signed [NOISE_W-1:0]  right_noise;
	logic        [STAMP_W-1:0]  stamp;

	modport source(output valid, left_pos, right_pos, left_noise, right_noise, stamp,
		input ready);
	modport sink(input valid, left_pos, right_pos, left_noise, right_noise, stamp,
		output ready);
endinterface

interface ddo_pose_if import ddo_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [31:0]         pos_x;
	logic signed [31:0]         pos_y;
	logic        [ANGLE_W-1:0]  heading;
	logic signed [QUAT_W-1:0]   quat_z;
	logic signed [QUAT_W-1:0]   quat_w;
	logic signed [31:0]         linear_vel;
	logic signed [31:0]         angular_vel;
	logic                       dt_zero;

	modport source(output valid, pos_x, pos_y, heading, quat_z, quat_w, linear_vel,
		angular_vel, dt_zero, input ready);
	modport sink(input valid, pos_x, pos_y, heading, quat_z, quat_w, linear_vel,
		angular_vel, dt_zero, output ready);
endinterface

// File: rtl/core/ddo_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, stops when no bits remain.
module ddo_mul import ddo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W-1:0] ma_q;
	logic [MUL_A_W-1:0] acc_q;
	logic [MUL_B_W-1:0] b_q;
	logic               neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= req.a[MUL_A_W-1] ? MUL_A_W'(-req.a) : MUL_A_W'(req.a);
			b_q   <= req.b;
			acc_q <= '0;
			neg_q <= req.a[MUL_A_W-1] ^ req.neg;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + ma_q;
			end
			ma_q <= ma_q << 1;
			b_q  <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.prod = neg_q ? $signed(-acc_q) : $signed(acc_q);

endmodule

// File: rtl/core/ddo_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// The divisor is taken as positive.
module ddo_div import ddo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   n_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   den_q;
	logic                 neg_q;
	logic [DIV_D_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, n_q[DIV_N_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num[DIV_N_W-1] ? DIV_N_W'(-req.num) : DIV_N_W'(req.num);
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[DIV_N_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, den_q}) : DIV_D_W'(trial);
			n_q   <= {n_q[DIV_N_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quo  = neg_q ? $signed(-n_q) : $signed(n_q);

endmodule

// File: rtl/core/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle. Angles in the left half
// plane are folded through pi and the result negated.
module ddo_cordic import ddo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cord_req_t req,
	output cord_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [CORD_CNT_W-1:0]       i_q;
	logic signed [CORD_W-1:0]    x_q;
	logic signed [CORD_W-1:0]    y_q;
	logic signed [CORD_Z_W-1:0]  z_q;
	logic                        flip_q;
	logic signed [CORD_W-1:0]    x_sh;
	logic signed [CORD_W-1:0]    y_sh;
	logic signed [CORD_Z_W-1:0]  step_ang;
	logic                        fold;
	logic [ANGLE_W-1:0]          folded;

	always_comb begin
		fold     = (req.angle > 32'h4000_0000) && (req.angle < 32'hC000_0000);
		folded   = fold ? req.angle + 32'h8000_0000 : req.angle;
		x_sh     = x_q >>> i_q;
		y_sh     = y_q >>> i_q;
		step_ang = $signed({2'b00, atan_ba(i_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == CORD_CNT_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORD_W'(TRIG_GAIN);
			y_q    <= '0;
			z_q    <= CORD_Z_W'($signed(folded));
			flip_q <= fold;
		end else if (busy_q) begin
			if (!z_q[CORD_Z_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - step_ang;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + step_ang;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.busy  = busy_q;
	assign rsp.cos_v = flip_q ? -x_q : x_q;
	assign rsp.sin_v = flip_q ? -y_q : y_q;

endmodule

// File: rtl/core/diff_drive_odometry.sv
// Differential-drive wheel odometry.
// sample: one transfer carries both wheel angles, a noise sample per wheel and
// a microsecond stamp. pose: one transfer per sample with x, y, heading, the
// yaw quaternion, linear and angular velocity and the zero-time-step flag.
// wr_en/wr_index/wr_data write the wheel radius (index 0) or the wheel separation
// (index 1); write only while no sample is in flight.
// A sample runs through a sequencer that drives one shift-add multiplier,
// one restoring divider and one CORDIC; a sample takes up to four divider
// passes. sample.ready is high only while the sequencer is idle, so a new
// sample is taken only once the previous one has left the sequencer.
// The finished pose sits in an output register: the next sample is taken
// while it waits, and the sequencer holds in its last step only if the
// previous pose is still not taken. A stall on pose never drops a result.
// Reset clears the previous angles, stamp, position accumulators and heading
// and loads the default radius and separation.
module diff_drive_odometry import ddo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	ddo_sample_if.sink            sample,
	ddo_pose_if.source            pose
);

	function automatic logic signed [31:0] sat32(input logic signed [DIV_N_W-1:0] v);
		logic signed [31:0] r;
		if (v > DIV_N_W'(32'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -DIV_N_W'(33'sh0_8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end else if (v < -64'sh0000_8000_0000_0000) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = ACC_W'(v);
		end
		return r;
	endfunction

	function automatic logic signed [QUAT_W-1:0] sat16(input logic signed [CORD_W-1:0] v);
		logic signed [CORD_W-1:0] t;
		logic signed [QUAT_W-1:0] r;
		t = v >>> 7;
		if (t > CORD_W'(32767)) begin
			r = 16'sh7FFF;
		end else if (t < -CORD_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = QUAT_W'(t);
		end
		return r;
	endfunction

	// Configuration
	logic [RADIUS_W-1:0] radius_q;
	logic [SEP_W-1:0]    sep_q;

	// Persistent state
	logic [ANGLE_W-1:0]        prev_left_q;
	logic [ANGLE_W-1:0]        prev_right_q;
	logic [STAMP_W-1:0]        prev_stamp_q;
	logic [ANGLE_W-1:0]        heading_q;
	logic signed [ACC_W-1:0]   acc_x_q;
	logic signed [ACC_W-1:0]   acc_y_q;

	// Per-sample working registers
	logic signed [32:0]        sum_q;
	logic signed [32:0]        dif_q;
	logic [STAMP_W-1:0]        dt_q;
	logic                      dt_zero_q;
	logic signed [RSUM_W-1:0]  rsum_q;
	logic signed [RSUM_W-1:0]  rdif_q;
	logic signed [63:0]        work_q;
	logic signed [CORD_W-1:0]  c_q;
	logic signed [CORD_W-1:0]  s_q;
	logic signed [QUAT_W-1:0]  qz_q;
	logic signed [QUAT_W-1:0]  qw_q;
	logic signed [31:0]        lin_q;
	logic signed [31:0]        ang_q;

	// Output register
	logic                      out_valid_q;
	logic signed [31:0]        pos_x_q;
	logic signed [31:0]        pos_y_q;
	logic [ANGLE_W-1:0]        heading_out_q;
	logic signed [QUAT_W-1:0]  quat_z_q;
	logic signed [QUAT_W-1:0]  quat_w_q;
	logic signed [31:0]        lin_out_q;
	logic signed [31:0]        ang_out_q;
	logic                      dt_zero_out_q;

	seq_state_t state_q, state_d;
	logic       launched_q;
	logic       accept;
	logic       out_load;

	mul_req_t  mul_req;
	mul_rsp_t  mul_rsp;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	cord_req_t cord_req;
	cord_rsp_t cord_rsp;

	logic [ANGLE_W-1:0]         new_left;
	logic [ANGLE_W-1:0]         new_right;
	logic signed [ANGLE_W-1:0]  dl;
	logic signed [ANGLE_W-1:0]  dr;
	logic signed [63:0]         ds;
	logic [CORD_W-1:0]          c_abs;
	logic [CORD_W-1:0]          s_abs;
	logic signed [63:0]         pos_inc;
	logic signed [55:0]         px_scaled;
	logic signed [55:0]         py_scaled;

	ddo_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	ddo_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	ddo_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(cord_req), .rsp(cord_rsp));

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || pose.ready);

	// Wheel deltas: noisy angle against the previous clean angle, wrapped.
	always_comb begin
		new_left  = sample.left_pos + ANGLE_W'(sample.left_noise);
		new_right = sample.right_pos + ANGLE_W'(sample.right_noise);
		dl        = $signed(new_left - prev_left_q);
		dr        = $signed(new_right - prev_right_q);
		ds        = 64'(rsum_q) >>> DS_SHIFT;
		c_abs     = c_q[CORD_W-1] ? CORD_W'(-c_q) : CORD_W'(c_q);
		s_abs     = s_q[CORD_W-1] ? CORD_W'(-s_q) : CORD_W'(s_q);
		pos_inc   = mul_rsp.prod >>> 22;
		px_scaled = (56'(acc_x_q) <<< POS_UP) >>> POS_DOWN;
		py_scaled = (56'(acc_y_q) <<< POS_UP) >>> POS_DOWN;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			sep_q    <= SEP_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_RADIUS: radius_q <= wr_data[RADIUS_W-1:0];
				REG_SEP:    sep_q    <= wr_data[SEP_W-1:0];
				default:    ;
			endcase
		end
	end

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_RSUM;
			ST_RSUM: if (mul_rsp.done) state_d = ST_RDIF;
			ST_RDIF: if (mul_rsp.done) state_d = (sep_q != '0) ? ST_TURN : ST_COS;
			ST_TURN: if (div_rsp.done) state_d = ST_BA;
			ST_BA:   if (mul_rsp.done) state_d = ST_COS;
			ST_COS:  if (cord_rsp.done) state_d = ST_XINC;
			ST_XINC: if (mul_rsp.done) state_d = ST_YINC;
			ST_YINC: if (mul_rsp.done) state_d = ST_HALF;
			ST_HALF: if (cord_rsp.done) state_d = dt_zero_q ? ST_OUT : ST_LINM;
			ST_LINM: if (mul_rsp.done) state_d = ST_LIND;
			ST_LIND: if (div_rsp.done) state_d = (sep_q != '0) ? ST_ANGM : ST_OUT;
			ST_ANGM: if (mul_rsp.done) state_d = ST_ANGT;
			ST_ANGT: if (div_rsp.done) state_d = ST_ANGD;
			ST_ANGD: if (div_rsp.done) state_d = ST_OUT;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer: unit requests. Each step launches its unit once on entry.
	always_comb begin
		mul_req  = '0;
		div_req  = '0;
		cord_req = '0;
		case (state_q)
			ST_RSUM: begin
				mul_req.start = !launched_q;
				mul_req.a     = 64'(sum_q);
				mul_req.b     = MUL_B_W'(radius_q);
			end
			ST_RDIF: begin
				mul_req.start = !launched_q;
				mul_req.a     = 64'(dif_q);
				mul_req.b     = MUL_B_W'(radius_q);
			end
			ST_TURN: begin
				div_req.start = !launched_q;
				div_req.num   = DIV_N_W'(rdif_q) <<< 8;
				div_req.den   = DIV_D_W'(sep_q);
			end
			ST_BA: begin
				mul_req.start = !launched_q;
				mul_req.a     = work_q;
				mul_req.b     = RAD_TO_BA;
			end
			ST_COS: begin
				cord_req.start = !launched_q;
				cord_req.angle = heading_q;
			end
			ST_XINC: begin
				mul_req.start = !launched_q;
				mul_req.a     = ds;
				mul_req.b     = MUL_B_W'(c_abs);
				mul_req.neg   = c_q[CORD_W-1];
			end
			ST_YINC: begin
				mul_req.start = !launched_q;
				mul_req.a     = ds;
				mul_req.b     = MUL_B_W'(s_abs);
				mul_req.neg   = s_q[CORD_W-1];
			end
			ST_HALF: begin
				cord_req.start = !launched_q;
				cord_req.angle = heading_q >> 1;
			end
			ST_LINM: begin
				mul_req.start = !launched_q;
				mul_req.a     = 64'(rsum_q);
				mul_req.b     = VEL_SCALE;
			end
			ST_LIND: begin
				div_req.start = !launched_q;
				div_req.num   = DIV_N_W'(work_q);
				div_req.den   = DIV_D_W'({dt_q, 11'b0});
			end
			ST_ANGM: begin
				mul_req.start = !launched_q;
				mul_req.a     = 64'(rdif_q);
				mul_req.b     = VEL_SCALE;
			end
			ST_ANGT: begin
				div_req.start = !launched_q;
				div_req.num   = DIV_N_W'(work_q);
				div_req.den   = DIV_D_W'(sep_q);
			end
			ST_ANGD: begin
				div_req.start = !launched_q;
				div_req.num   = DIV_N_W'(work_q) <<< 6;
				div_req.den   = DIV_D_W'(dt_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			launched_q <= (state_d == state_q) && (state_q != ST_IDLE) && (state_q != ST_OUT);
		end
	end

	// Persistent state: reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
			prev_stamp_q <= '0;
			heading_q    <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
		end else begin
			if (accept) begin
				// store the clean angles, not the noisy ones
				prev_left_q  <= sample.left_pos;
				prev_right_q <= sample.right_pos;
				prev_stamp_q <= sample.stamp;
			end
			if ((state_q == ST_BA) && mul_rsp.done) begin
				// turn as binary angle: bits 55:24 of q24 * (2^32 / 2pi)
				heading_q <= heading_q + mul_rsp.prod[55:24];
			end
			if ((state_q == ST_XINC) && mul_rsp.done) begin
				acc_x_q <= sat_acc(64'(acc_x_q) + pos_inc);
			end
			if ((state_q == ST_YINC) && mul_rsp.done) begin
				acc_y_q <= sat_acc(64'(acc_y_q) + pos_inc);
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q     <= 33'(dl) + 33'(dr);
			dif_q     <= 33'(dr) - 33'(dl);
			dt_q      <= sample.stamp - prev_stamp_q;
			dt_zero_q <= (sample.stamp == prev_stamp_q);
			lin_q     <= '0;
			ang_q     <= '0;
		end
		case (state_q)
			ST_RSUM: if (mul_rsp.done) rsum_q <= RSUM_W'(mul_rsp.prod);
			ST_RDIF: if (mul_rsp.done) rdif_q <= RSUM_W'(mul_rsp.prod);
			ST_TURN: if (div_rsp.done) work_q <= 64'(div_rsp.quo);
			ST_COS: begin
				if (cord_rsp.done) begin
					c_q <= cord_rsp.cos_v;
					s_q <= cord_rsp.sin_v;
				end
			end
			ST_HALF: begin
				if (cord_rsp.done) begin
					qz_q <= sat16(cord_rsp.sin_v);
					qw_q <= sat16(cord_rsp.cos_v);
				end
			end
			ST_LINM: if (mul_rsp.done) work_q <= mul_rsp.prod;
			ST_LIND: if (div_rsp.done) lin_q <= sat32(div_rsp.quo);
			ST_ANGM: if (mul_rsp.done) work_q <= mul_rsp.prod;
			ST_ANGT: if (div_rsp.done) work_q <= 64'(div_rsp.quo);
			ST_ANGD: if (div_rsp.done) ang_q <= sat32(div_rsp.quo);
			default: ;
		endcase
	end

	// Output register: load when empty or being drained, hold under stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pose.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x_q       <= sat32(DIV_N_W'(px_scaled));
			pos_y_q       <= sat32(DIV_N_W'(py_scaled));
			heading_out_q <= heading_q;
			quat_z_q      <= qz_q;
			quat_w_q      <= qw_q;
			lin_out_q     <= lin_q;
			ang_out_q     <= ang_q;
			dt_zero_out_q <= dt_zero_q;
		end
	end

	assign pose.valid       = out_valid_q;
	assign pose.pos_x       = pos_x_q;
	assign pose.pos_y       = pos_y_q;
	assign pose.heading     = heading_out_q;
	assign pose.quat_z      = quat_z_q;
	assign pose.quat_w      = quat_w_q;
	assign pose.linear_vel  = lin_out_q;
	assign pose.angular_vel = ang_out_q;
	assign pose.dt_zero     = dt_zero_out_q;

	// A new pose appears only out of the final step
	a_pose_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose.valid) |-> $past(state_q == ST_OUT))
		else $error("pose valid rose outside the output step");

	// An accepted sample always starts the sequencer
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RSUM))
		else $error("accepted sample did not start the sequence");

	// Only one arithmetic unit is at work at a time
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_rsp.busy, div_rsp.busy, cord_rsp.busy}))
		else $error("more than one arithmetic unit busy");

	// No unit is running while the sequencer is idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(mul_rsp.busy || div_rsp.busy || cord_rsp.busy))
		else $error("arithmetic unit busy while idle");

endmodule
